[rtl/tbcpm_pkg.sv]
// Shared constants for the tiny/big cluster proximity merge block.
// Holds point store sizing, field widths, opcodes and register indexes.
// No dependencies.
package tbcpm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PTR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W = 16;
    localparam int POINT_W = 2 * COORD_W;
    localparam int HITS_W  = 17;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int CUT_W   = 34;

    localparam int OPCODE_W = 2;
    localparam logic [OPCODE_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EVALUATE    = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CUT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_CUT   = 3'd4;

    localparam logic [HITS_W-1:0] SMALL_HIGH_RST = 17'd15;
    localparam logic [HITS_W-1:0] BIG_LOW_RST    = 17'd50;
    localparam logic [HITS_W-1:0] BIG_HIGH_RST   = 17'd99999;

endpackage

[rtl/tiny_big_cluster_proximity_merge_core.sv]
// Tiny/big cluster proximity merge: top level with both vertex stores and the pair walker.
// Depends on tbcpm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per handshake. Opcode
//   load-first and load-second append a (wire, time) vertex to the first or
//   second polygon store; a load into a full store is dropped. Opcode evaluate
//   classifies both hit counts, walks every vertex pair and returns one item on
//   the output channel (out_valid / out_stall) with merge set when exactly one
//   cluster is small, exactly one is big and some pair lies closer than the
//   squared-distance cut. Evaluate empties both stores. Opcode 3 is ignored.
//   An evaluate with N1 and N2 stored points walks the N1 * N2 pairs row by row:
//   the second store is streamed through its single read port, one pair per
//   cycle, and the first store is re-read once per row. The walk stops early on
//   the first close pair. An evaluate whose class test fails or whose store is
//   empty skips the walk and goes straight to the finish state. in_stall is high
//   while an evaluate is in progress.
//   The result sits in an output register; the block keeps taking loads while
//   the receiver stalls it, and a later evaluate waits for that register.
//   Reset empties both stores (no clearing pass; entries beyond the fill count
//   are never read) and loads the configuration defaults. Configuration is
//   written through cfg_we / cfg_index / cfg_wdata; unknown indexes are ignored.
module tiny_big_cluster_proximity_merge_core
    import tbcpm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [OPCODE_W-1:0]         opcode,
    input  logic signed [COORD_W-1:0]   point_wire,
    input  logic signed [COORD_W-1:0]   point_time,
    input  logic [HITS_W-1:0]           hits_first,
    input  logic [HITS_W-1:0]           hits_second,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        merge
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PRIME,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Configuration registers
    logic [HITS_W-1:0] small_low_reg;
    logic [HITS_W-1:0] small_high_reg;
    logic [HITS_W-1:0] big_low_reg;
    logic [HITS_W-1:0] big_high_reg;
    logic [CUT_W-1:0]  dist_cut_reg;

    // Control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] first_count_reg, first_count_next;
    logic [CNT_W-1:0] second_count_reg, second_count_next;
    logic [CNT_W-1:0] n1_reg, n1_next;
    logic [CNT_W-1:0] n2_reg, n2_next;
    logic [PTR_W-1:0] i_reg, i_next;
    logic [PTR_W-1:0] j_reg, j_next;
    logic             hit_reg, hit_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             sq_vld_reg, sq_vld_next;
    logic             out_valid_reg, out_valid_next;
    logic             merge_reg, merge_next;

    // Vertex stores and datapath
    logic [POINT_W-1:0] first_mem [MAX_POINTS];
    logic [POINT_W-1:0] second_mem [MAX_POINTS];
    logic [POINT_W-1:0] first_q;
    logic [POINT_W-1:0] second_q;
    logic [POINT_W-1:0] p_reg;
    logic [SQ_W-1:0]    sq_w_reg;
    logic [SQ_W-1:0]    sq_t_reg;

    logic               in_acc;
    logic [POINT_W-1:0] in_point;
    logic               first_we;
    logic               second_we;
    logic               small_a, small_b, big_a, big_b, class_ok;
    logic signed [DIFF_W-1:0]   diff_w, diff_t;
    logic signed [2*DIFF_W-1:0] prod_w, prod_t;
    logic [DIST_W-1:0]  dist_sum;
    logic               close_pair;
    logic               last_j, last_i;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign in_point  = {point_wire, point_time};
    assign out_valid = out_valid_reg;
    assign merge     = merge_reg;

    assign first_we  = in_acc && (opcode == OP_LOAD_FIRST)
                       && (first_count_reg < CNT_W'(MAX_POINTS));
    assign second_we = in_acc && (opcode == OP_LOAD_SECOND)
                       && (second_count_reg < CNT_W'(MAX_POINTS));

    // Classify both clusters; bounds are exclusive
    assign small_a  = (hits_first > small_low_reg) && (hits_first < small_high_reg);
    assign small_b  = (hits_second > small_low_reg) && (hits_second < small_high_reg);
    assign big_a    = (hits_first > big_low_reg) && (hits_first < big_high_reg);
    assign big_b    = (hits_second > big_low_reg) && (hits_second < big_high_reg);
    assign class_ok = (small_a != small_b) && (big_a != big_b);

    assign last_j = ((CNT_W'(j_reg) + CNT_W'(1)) == n2_reg);
    assign last_i = ((CNT_W'(i_reg) + CNT_W'(1)) == n1_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_low_reg  <= '0;
            small_high_reg <= SMALL_HIGH_RST;
            big_low_reg    <= BIG_LOW_RST;
            big_high_reg   <= BIG_HIGH_RST;
            dist_cut_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMALL_LOW:  small_low_reg  <= cfg_wdata[HITS_W-1:0];
                CFG_SMALL_HIGH: small_high_reg <= cfg_wdata[HITS_W-1:0];
                CFG_BIG_LOW:    big_low_reg    <= cfg_wdata[HITS_W-1:0];
                CFG_BIG_HIGH:   big_high_reg   <= cfg_wdata[HITS_W-1:0];
                CFG_DIST_CUT:   dist_cut_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // First polygon store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_count_reg[PTR_W-1:0]] <= in_point;
        end
        first_q <= first_mem[i_reg];
    end

    // Second polygon store: streamed one entry per cycle during the walk
    always_ff @(posedge clk)
    begin
        if (second_we)
        begin
            second_mem[second_count_reg[PTR_W-1:0]] <= in_point;
        end
        second_q <= second_mem[j_reg];
    end

    // Pair datapath: differences and squares, then sum and compare
    assign diff_w = DIFF_W'($signed(second_q[POINT_W-1:COORD_W]))
                  - DIFF_W'($signed(p_reg[POINT_W-1:COORD_W]));
    assign diff_t = DIFF_W'($signed(second_q[COORD_W-1:0]))
                  - DIFF_W'($signed(p_reg[COORD_W-1:0]));
    assign prod_w = diff_w * diff_w;
    assign prod_t = diff_t * diff_t;
    assign dist_sum   = DIST_W'(sq_w_reg) + DIST_W'(sq_t_reg);
    assign close_pair = (CUT_W'(dist_sum) < dist_cut_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PRIME)
        begin
            p_reg <= first_q;
        end
        sq_w_reg <= prod_w[SQ_W-1:0];
        sq_t_reg <= prod_t[SQ_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        n1_next           = n1_reg;
        n2_next           = n2_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        hit_next          = hit_reg;
        rd_vld_next       = (state_reg == ST_RUN);
        sq_vld_next       = rd_vld_reg;
        out_valid_next    = out_valid_reg && out_stall;
        merge_next        = merge_reg;

        // Latch any close pair coming out of the pipeline
        if (sq_vld_reg && close_pair)
        begin
            hit_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (first_we)
                begin
                    first_count_next = first_count_reg + CNT_W'(1);
                end
                if (second_we)
                begin
                    second_count_next = second_count_reg + CNT_W'(1);
                end
                if (in_acc && (opcode == OP_EVALUATE))
                begin
                    n1_next           = first_count_reg;
                    n2_next           = second_count_reg;
                    first_count_next  = '0;
                    second_count_next = '0;
                    i_next            = '0;
                    hit_next          = 1'b0;
                    if (class_ok && (first_count_reg != '0) && (second_count_reg != '0))
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FETCH:
            begin
                // Read of first_mem[i] is in flight
                state_next = hit_reg ? ST_DRAIN : ST_PRIME;
            end
            ST_PRIME:
            begin
                j_next     = '0;
                state_next = hit_reg ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                j_next = j_reg + PTR_W'(1);
                if (last_j)
                begin
                    if (last_i || hit_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next     = i_reg + PTR_W'(1);
                        state_next = ST_FETCH;
                    end
                end
                else if (hit_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !sq_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    merge_next     = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            n1_reg           <= '0;
            n2_reg           <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            hit_reg          <= 1'b0;
            rd_vld_reg       <= 1'b0;
            sq_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            merge_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            n1_reg           <= n1_next;
            n2_reg           <= n2_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            hit_reg          <= hit_next;
            rd_vld_reg       <= rd_vld_next;
            sq_vld_reg       <= sq_vld_next;
            out_valid_reg    <= out_valid_next;
            merge_reg        <= merge_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CNT_W'(MAX_POINTS)) && (second_count_reg <= CNT_W'(MAX_POINTS)))
        else $error("point count exceeds store depth");

    a_eval_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (opcode == OP_EVALUATE)) |=>
        (first_count_reg == '0) && (second_count_reg == '0))
        else $error("evaluate did not empty the stores");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((CNT_W'(j_reg) < n2_reg) && (CNT_W'(i_reg) < n1_reg)))
        else $error("pair walk out of bounds");
`endif

endmodule

[tb/sv/tb.sv]
// Testbench for tiny_big_cluster_proximity_merge_core: a directed stimulus table, then random
// cluster pairs, each result checked against an in-bench merge decision model.
// Depends on tbcpm_pkg and the core RTL; reads no files.
module tb;
    import tbcpm_pkg::*;

    localparam logic [OPCODE_W-1:0]   OP_UNUSED          = 2'd3;
    localparam logic [CFG_IDX_W-1:0]  CFG_FIRST_UNMAPPED = 3'd5;
    localparam logic [HITS_W-1:0]     HITS_MAX           = 17'h1FFFF;
    localparam logic [CUT_W-1:0]      CUT_MAX            = 34'h3FFFFFFFF;
    localparam int RANDOM_ITEMS    = 1900;
    localparam int RANDOM_PHASES   = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    // Watchdog limit, well above the longest evaluate with both stores full.
    localparam int WATCHDOG_CYCLES = 20000;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One line of the directed table: either an item or a register write.
    typedef struct packed {
        row_kind_t               kind;
        logic [OPCODE_W-1:0]     op;
        logic [COORD_W-1:0]      wire_pos;
        logic [COORD_W-1:0]      time_pos;
        logic [HITS_W-1:0]       hits_a;
        logic [HITS_W-1:0]       hits_b;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic                    typed;
        logic                    typed_merge;
    } directed_row_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] wire_pos;
        logic signed [COORD_W-1:0] time_pos;
    } vertex_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [OPCODE_W-1:0]         opcode = '0;
    logic signed [COORD_W-1:0]   point_wire = '0;
    logic signed [COORD_W-1:0]   point_time = '0;
    logic [HITS_W-1:0]           hits_first = '0;
    logic [HITS_W-1:0]           hits_second = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        merge;

    // Decision model state: vertex stores, fill counts and register copies.
    vertex_t                     first_store [MAX_POINTS];
    vertex_t                     second_store [MAX_POINTS];
    int                          first_fill = 0;
    int                          second_fill = 0;
    logic [HITS_W-1:0]           small_lo = '0;
    logic [HITS_W-1:0]           small_hi = SMALL_HIGH_RST;
    logic [HITS_W-1:0]           big_lo = BIG_LOW_RST;
    logic [HITS_W-1:0]           big_hi = BIG_HIGH_RST;
    logic [CUT_W-1:0]            cut_sq = '0;

    bit                          merge_expected [$];
    directed_row_t               directed_rows [$];
    int                          mismatches = 0;
    int                          items_sent = 0;
    int                          quiet_cycles = 0;
    int                          stall_run = 0;
    logic [31:0]                 cycle_count = '0;

    tiny_big_cluster_proximity_merge_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .point_wire  (point_wire),
        .point_time  (point_time),
        .hits_first  (hits_first),
        .hits_second (hits_second),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .merge       (merge)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Merge decision model
    // ------------------------------------------------------------------

    function automatic bit in_band(input logic [HITS_W-1:0] h, lo, hi);
        return (h > lo) && (h < hi);
    endfunction

    // Exact squared distance over every (first, second) vertex pair.
    function automatic bit pair_within_cut();
        longint dw;
        longint dt;
        for (int i = 0; i < first_fill; i++)
        begin
            for (int j = 0; j < second_fill; j++)
            begin
                dw = longint'($signed(first_store[i].wire_pos))
                     - longint'($signed(second_store[j].wire_pos));
                dt = longint'($signed(first_store[i].time_pos))
                     - longint'($signed(second_store[j].time_pos));
                if (dw * dw + dt * dt < longint'(cut_sq))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void merge_decision(input logic [OPCODE_W-1:0] op,
                                           input logic signed [COORD_W-1:0] w, t,
                                           input logic [HITS_W-1:0] h1, h2,
                                           output bit has_result, output bit merge_out);
        has_result = 1'b0;
        merge_out  = 1'b0;
        case (op)
            OP_LOAD_FIRST:
            begin
                // Drop loads into a full store.
                if (first_fill < MAX_POINTS)
                begin
                    first_store[first_fill].wire_pos = w;
                    first_store[first_fill].time_pos = t;
                    first_fill++;
                end
            end
            OP_LOAD_SECOND:
            begin
                if (second_fill < MAX_POINTS)
                begin
                    second_store[second_fill].wire_pos = w;
                    second_store[second_fill].time_pos = t;
                    second_fill++;
                end
            end
            OP_EVALUATE:
            begin
                has_result = 1'b1;
                merge_out  = (in_band(h1, small_lo, small_hi) != in_band(h2, small_lo, small_hi))
                             && (in_band(h1, big_lo, big_hi) != in_band(h2, big_lo, big_hi))
                             && pair_within_cut();
                first_fill  = 0;
                second_fill = 0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Pacing
    // ------------------------------------------------------------------

    // Sender gap: mostly none or short, a few long; no gaps in quiet windows.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count[9:8] == 2'd0)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver stall: random runs, short mostly, with stall-free windows.
    always @(posedge clk)
    begin : receiver_pace
        int r;
        r = $urandom_range(0, 99);
        if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run--;
        end
        else if (cycle_count[10:9] == 2'd1 || r < 60)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= 1'b1;
            stall_run = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present one item, hold it until accepted, then predict and maybe idle.
    task automatic drive_item(input logic [OPCODE_W-1:0] op,
                              input logic signed [COORD_W-1:0] w, t,
                              input logic [HITS_W-1:0] h1, h2,
                              input bit typed = 1'b0, input bit typed_merge = 1'b0);
        bit has_result;
        bit predicted;
        int gap;
        in_valid    <= 1'b1;
        opcode      <= op;
        point_wire  <= w;
        point_time  <= t;
        hits_first  <= h1;
        hits_second <= h2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        merge_decision(op, w, t, h1, h2, has_result, predicted);
        // A typed row states its own expectation; the model state still advances.
        if (has_result)
            merge_expected.push_back(typed ? typed_merge : predicted);
        if (op != OP_UNUSED)
            items_sent++;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write one register; cfg_we stays high so back-to-back writes need no toggle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_SMALL_LOW:  small_lo = val[HITS_W-1:0];
            CFG_SMALL_HIGH: small_hi = val[HITS_W-1:0];
            CFG_BIG_LOW:    big_lo   = val[HITS_W-1:0];
            CFG_BIG_HIGH:   big_hi   = val[HITS_W-1:0];
            CFG_DIST_CUT:   cut_sq   = val;
            default: ;
        endcase
    endtask

    // Drain every pending result, then let trailing loads land.
    task automatic settle();
        in_valid <= 1'b0;
        while (merge_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------

    function automatic void item_row(input logic [OPCODE_W-1:0] op,
                                     input logic [COORD_W-1:0] w, t,
                                     input logic [HITS_W-1:0] h1 = '0, h2 = '0,
                                     input bit typed = 1'b0, input bit typed_merge = 1'b0);
        directed_row_t r;
        r             = '0;
        r.kind        = ROW_ITEM;
        r.op          = op;
        r.wire_pos    = w;
        r.time_pos    = t;
        r.hits_a      = h1;
        r.hits_b      = h2;
        r.typed       = typed;
        r.typed_merge = typed_merge;
        directed_rows.push_back(r);
    endfunction

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        directed_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void build_directed_table();
        // Reset settings: the cut is zero, so nothing is ever close enough.
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd1, 17'd60, 1'b1, 1'b0); // both empty
        item_row(OP_LOAD_FIRST,  16'h0000, 16'h0000);
        item_row(OP_LOAD_SECOND, 16'h0000, 16'h0000);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd5, 17'd60, 1'b1, 1'b0); // cut zero
        reg_row(CFG_DIST_CUT, CUT_MAX);
        reg_row(CFG_FIRST_UNMAPPED, '1);                        // must be ignored
        // Opposite corners: the largest distance still falls under the largest cut.
        item_row(OP_LOAD_FIRST,  16'h8000, 16'h8000);
        item_row(OP_LOAD_SECOND, 16'h7FFF, 16'h7FFF);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd14, 17'd51);
        // Class bounds are exclusive: 15 is not small.
        item_row(OP_LOAD_FIRST,  16'h0001, 16'h0001);
        item_row(OP_LOAD_SECOND, 16'h0001, 16'h0001);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd15, 17'd51);
        item_row(OP_LOAD_FIRST,  16'h0001, 16'h0001);
        item_row(OP_LOAD_SECOND, 16'h0002, 16'h0002);
        item_row(OP_EVALUATE,    16'hFFFF, 16'hFFFF, 17'd99998, 17'd1);
        // Second store empty.
        item_row(OP_LOAD_FIRST,  16'h7FFF, 16'h8000);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd60, 17'd5, 1'b1, 1'b0);
        // Unused opcode with every field at its top: loads nothing.
        item_row(OP_UNUSED,      16'hFFFF, 16'hFFFF, HITS_MAX, HITS_MAX);
        item_row(OP_LOAD_FIRST,  16'h0000, 16'h0000);
        item_row(OP_LOAD_SECOND, 16'h0000, 16'h0000);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd5, 17'd5, 1'b1, 1'b0); // both small
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, HITS_MAX, 17'd0, 1'b1, 1'b0);
        // Distance exactly on the cut does not merge; just below it does.
        reg_row(CFG_DIST_CUT, 34'd25);
        item_row(OP_LOAD_FIRST,  16'h0000, 16'h0000);
        item_row(OP_LOAD_SECOND, 16'h0003, 16'h0004);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd5, 17'd60);
        item_row(OP_LOAD_FIRST,  16'h0000, 16'h0000);
        item_row(OP_LOAD_SECOND, 16'hFFFE, 16'h0004);
        item_row(OP_EVALUATE,    16'h0000, 16'h0000, 17'd60, 17'd5);
    endfunction

    // ------------------------------------------------------------------
    // Random cluster pairs
    // ------------------------------------------------------------------

    // Hit count near a class boundary, inside it, or anywhere.
    function automatic logic [HITS_W-1:0] hits_near(input logic [HITS_W-1:0] lo, hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return lo + 17'd1;
            2: return hi - 17'd1;
            3: return hi;
            4, 5:
            begin
                if (int'(hi) > int'(lo) + 1)
                    return lo + 17'(1 + $urandom_range(0, int'(hi) - int'(lo) - 2));
                return 17'($urandom);
            end
            6: return 17'($urandom);
            default: return $urandom_range(0, 1) ? HITS_MAX : 17'd0;
        endcase
    endfunction

    // Mostly a few vertices, sometimes more, now and then past capacity.
    function automatic int vertex_total();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return $urandom_range(60, 72);
        if (r < 12)
            return $urandom_range(7, 20);
        return $urandom_range(1, 6);
    endfunction

    function automatic logic signed [COORD_W-1:0] jitter(input logic signed [COORD_W-1:0] center,
                                                         input int spread);
        return center + 16'($urandom_range(0, 2 * spread - 1)) - 16'(spread);
    endfunction

    // Load two polygons around a shared center in random interleave, then evaluate.
    task automatic run_cluster_pair();
        int shape;
        int n1;
        int n2;
        int l1;
        int l2;
        int spread;
        logic signed [COORD_W-1:0] cw;
        logic signed [COORD_W-1:0] ct;
        logic [HITS_W-1:0] h_small;
        logic [HITS_W-1:0] h_big;
        shape  = $urandom_range(0, 99);
        n1     = vertex_total();
        n2     = vertex_total();
        spread = 1 << $urandom_range(0, 15);
        cw     = 16'($urandom);
        ct     = 16'($urandom);
        l1     = 0;
        l2     = 0;
        // Broken pairs: one polygon left empty.
        if (shape < 3)
            n1 = 0;
        else if (shape < 6)
            n2 = 0;
        while (l1 < n1 || l2 < n2)
        begin
            if ($urandom_range(0, 29) == 0)
                drive_item(OP_UNUSED, 16'($urandom), 16'($urandom), 17'($urandom), 17'($urandom));
            if (l2 >= n2 || (l1 < n1 && $urandom_range(0, 1) == 1))
            begin
                drive_item(OP_LOAD_FIRST, jitter(cw, spread), jitter(ct, spread),
                           17'($urandom), 17'($urandom));
                l1++;
            end
            else
            begin
                drive_item(OP_LOAD_SECOND, jitter(cw, spread), jitter(ct, spread),
                           17'($urandom), 17'($urandom));
                l2++;
            end
        end
        h_small = hits_near(small_lo, small_hi);
        h_big   = hits_near(big_lo, big_hi);
        if (shape < 12)
            drive_item(OP_EVALUATE, 16'($urandom), 16'($urandom), 17'($urandom), 17'($urandom));
        else if ($urandom_range(0, 1) == 1)
            drive_item(OP_EVALUATE, 16'($urandom), 16'($urandom), h_small, h_big);
        else
            drive_item(OP_EVALUATE, 16'($urandom), 16'($urandom), h_big, h_small);
    endtask

    // Per-phase register settings: moderate, all-open extremes, all-closed extremes, wild.
    task automatic write_phase_config(input int phase);
        logic [HITS_W-1:0] s_lo;
        logic [HITS_W-1:0] s_hi;
        logic [HITS_W-1:0] b_lo;
        logic [HITS_W-1:0] b_hi;
        logic [CUT_W-1:0]  cut;
        logic [63:0]       r64;
        r64 = {$urandom, $urandom};
        case (phase % 4)
            0:
            begin
                s_lo = 17'($urandom_range(0, 8));
                s_hi = s_lo + 17'($urandom_range(2, 40));
                b_lo = 17'($urandom_range(20, 300));
                b_hi = b_lo + 17'($urandom_range(2, 3000));
                cut  = 34'(r64 >> $urandom_range(30, 63));
            end
            1:
            begin
                s_lo = '0;
                s_hi = HITS_MAX;
                b_lo = '0;
                b_hi = HITS_MAX;
                cut  = CUT_MAX;
            end
            2:
            begin
                s_lo = HITS_MAX;
                s_hi = '0;
                b_lo = HITS_MAX;
                b_hi = '0;
                cut  = '0;
            end
            default:
            begin
                s_lo = 17'($urandom);
                s_hi = 17'($urandom);
                b_lo = 17'($urandom);
                b_hi = 17'($urandom);
                cut  = 34'(r64);
            end
        endcase
        // Junk in the upper data bits must not reach the 17-bit registers.
        cfg_write(CFG_SMALL_LOW,  {17'($urandom), s_lo});
        cfg_write(CFG_SMALL_HIGH, {17'($urandom), s_hi});
        cfg_write(CFG_BIG_LOW,    {17'($urandom), b_lo});
        cfg_write(CFG_BIG_HIGH,   {17'($urandom), b_hi});
        cfg_write(CFG_DIST_CUT,   cut);
        cfg_write(CFG_FIRST_UNMAPPED + 3'($urandom_range(0, 2)), 34'({$urandom, $urandom}));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result check and watchdog
    // ------------------------------------------------------------------

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin : check_result
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (merge_expected.size() == 0)
                report_mismatch("result with no evaluate pending");
            else
            begin
                want = merge_expected.pop_front();
                if (merge !== want)
                    report_mismatch($sformatf("merge got %b want %b", merge, want));
            end
        end
    end

    // Count cycles with no handshake and no register write; give up at the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 32'd1;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no progress for %0d cycles", quiet_cycles);
            $display("FAIL tiny_big_cluster_proximity_merge_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        directed_row_t row;
        bit prev_cfg;
        int base_items;
        prev_cfg = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; register rows wait for the block to go idle.
        build_directed_table();
        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    settle();
                cfg_write(row.reg_idx, row.reg_val);
                prev_cfg = 1'b1;
            end
            else
            begin
                if (prev_cfg)
                    cfg_we <= 1'b0;
                drive_item(row.op, row.wire_pos, row.time_pos, row.hits_a, row.hits_b,
                           row.typed, row.typed_merge);
                prev_cfg = 1'b0;
            end
        end

        // Random phases, each under its own register settings.
        base_items = items_sent;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            write_phase_config(phase);
            while (items_sent < base_items + (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES)
                run_cluster_pair();
        end

        // Drain, then keep watching for any stray result before the verdict.
        in_valid <= 1'b0;
        while (merge_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS tiny_big_cluster_proximity_merge_core");
        else
            $display("FAIL tiny_big_cluster_proximity_merge_core");
        $finish;
    end

endmodule

[sim.f]
rtl/tbcpm_pkg.sv
rtl/tiny_big_cluster_proximity_merge_core.sv
tb/sv/tb.sv
